// ===== hw/rtl/csre_pkg.sv =====
// Shared types and constants for the color-key sprite run-length encoder.
// No dependencies; every other file in hw/rtl refers to this package.
package csre_pkg;

    localparam logic [2:0] OP_END  = 3'd0;
    localparam logic [2:0] OP_ENDL = 3'd1;
    localparam logic [2:0] OP_SKIP = 3'd2;
    localparam logic [2:0] OP_COPY = 3'd4;

    localparam logic [1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_TILE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PIXEL_BYTES = 2'd2;
    localparam logic [1:0] CFG_COLOR_KEY   = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [5:0]  tile_width;
        logic [15:0] tile_height;
        logic [2:0]  pixel_bytes;
        logic [31:0] color_key;
    } cfg_t;

    // one classified pixel handed from front to back
    typedef struct packed {
        logic [31:0] pixel;     // already masked to the pixel size
        logic        transp;
        logic        row_end;
        logic        tile_end;
    } item_t;

endpackage

// ===== hw/rtl/csre_front.sv =====
// Front end: takes pixels, masks and keys them, tracks column and row.
// Depends on csre_pkg; pushes classified words into csre_queue.
module csre_front #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  csre_pkg::cfg_t      cfg,
    input  logic [31:0]         pixel,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  logic                q_full,
    output logic                q_push,
    output csre_pkg::item_t     q_item
);

    logic [5:0]  column_reg, column_next;
    logic [15:0] row_reg, row_next;
    logic [2:0]  nbytes;
    logic [5:0]  nbits;
    logic [31:0] mask;
    logic [31:0] px;
    logic [5:0]  w_eff;
    logic [15:0] h_eff;
    logic        row_end;
    logic        tile_end;

    always_comb
    begin
        if (cfg.pixel_bytes == 3'd0)
            nbytes = 3'd1;
        else if (cfg.pixel_bytes > 3'd4)
            nbytes = 3'd4;
        else
            nbytes = cfg.pixel_bytes;
        nbits = {nbytes, 3'b000};
        if (nbits > 6'(PIXEL_BITS))
            nbits = 6'(PIXEL_BITS);
        if (nbits >= 6'd32)
            mask = '1;
        else
            mask = (32'd1 << nbits) - 32'd1;

        if (cfg.tile_width == 6'd0)
            w_eff = 6'd1;
        else if (cfg.tile_width > 6'(MAX_WIDTH))
            w_eff = 6'(MAX_WIDTH);
        else
            w_eff = cfg.tile_width;
        h_eff = (cfg.tile_height == 16'd0) ? 16'd1 : cfg.tile_height;

        px       = pixel & mask;
        row_end  = ({1'b0, column_reg} + 7'd1) >= {1'b0, w_eff};
        tile_end = row_end && (({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff});

        pixel_stall     = q_full;
        q_push          = pixel_valid && !q_full;
        q_item.pixel    = px;
        q_item.transp   = (px == (cfg.color_key & mask));
        q_item.row_end  = row_end;
        q_item.tile_end = tile_end;

        column_next = column_reg;
        row_next    = row_reg;
        if (q_push)
        begin
            if (row_end)
            begin
                column_next = 6'd0;
                row_next    = tile_end ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                column_next = column_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= 6'd0;
            row_reg    <= 16'd0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ===== hw/rtl/csre_queue.sv =====
// Short queue of classified pixel words between front and back.
// Depends on csre_pkg for the word type and depth.
module csre_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csre_pkg::item_t push_item,
    output logic            full,
    output logic            q_valid,
    output csre_pkg::item_t q_item,
    input  logic            pop
);

    localparam int PW = (csre_pkg::QUEUE_DEPTH > 1) ? $clog2(csre_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(csre_pkg::QUEUE_DEPTH + 1);

    csre_pkg::item_t slots_reg [csre_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(csre_pkg::QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PW'(1);
        return r;
    endfunction

    always_comb
    begin
        full        = (count_reg == NW'(csre_pkg::QUEUE_DEPTH));
        q_valid     = (count_reg != '0);
        q_item      = slots_reg[rd_ptr_reg];
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(csre_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/csre_back.sv =====
// Back end: run buffer and op sequencer; emits SKIP/COPY/pixel/ENDL/END words.
// Depends on csre_pkg; pops classified words from csre_queue.
module csre_back #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  csre_pkg::item_t q_item,
    output logic            q_pop,
    output logic            result_valid,
    input  logic            result_stall,
    output logic            kind,
    output logic [2:0]      op_code,
    output logic [15:0]     run_length,
    output logic [31:0]     pixel_out,
    output logic            last
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SKIP = 3'd1;
    localparam logic [2:0] ST_COPY = 3'd2;
    localparam logic [2:0] ST_PIX  = 3'd3;
    localparam logic [2:0] ST_EOL  = 3'd4;

    logic [PIXEL_BITS-1:0] buf_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [15:0]   skip_reg, skip_next;
    logic          transp_reg, transp_next;
    logic          row_end_reg, row_end_next;
    logic          tile_end_reg, tile_end_next;

    logic          ovalid_reg, ovalid_next;
    logic          kind_reg, kind_next;
    logic [2:0]    op_reg, op_next;
    logic [15:0]   len_reg, len_next;
    logic [31:0]   pix_reg, pix_next;
    logic          last_reg, last_next;

    logic          adv;
    logic          mem_we;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] cnt_after;
    logic [CW-1:0] idx_inc;
    logic          pix_done;

    always_comb
    begin
        adv      = !ovalid_reg || !result_stall;
        idx_inc  = idx_reg + CW'(1);
        pix_done = (idx_inc == cnt_reg);

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        skip_next     = skip_reg;
        transp_next   = transp_reg;
        row_end_next  = row_end_reg;
        tile_end_next = tile_end_reg;

        ovalid_next = adv ? 1'b0 : ovalid_reg;
        kind_next   = kind_reg;
        op_next     = op_reg;
        len_next    = len_reg;
        pix_next    = pix_reg;
        last_next   = last_reg;

        q_pop     = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        cnt_after = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    transp_next   = q_item.transp;
                    row_end_next  = q_item.row_end;
                    tile_end_next = q_item.tile_end;
                    if (!q_item.transp && (cnt_reg < CW'(MAX_WIDTH)))
                    begin
                        mem_we    = 1'b1;
                        cnt_after = cnt_reg + CW'(1);
                    end
                    cnt_next = cnt_after;
                    if ((q_item.transp || q_item.row_end) && (cnt_after != '0))
                        state_next = (skip_reg != 16'd0) ? ST_SKIP : ST_COPY;
                    else if (q_item.row_end)
                        state_next = ST_EOL;
                    else if (q_item.transp)
                        skip_next = skip_reg + 16'd1;
                end
            end
            ST_SKIP:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    kind_next   = 1'b0;
                    op_next     = csre_pkg::OP_SKIP;
                    len_next    = skip_reg;
                    pix_next    = '0;
                    last_next   = 1'b0;
                    state_next  = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    kind_next   = 1'b0;
                    op_next     = csre_pkg::OP_COPY;
                    len_next    = 16'(cnt_reg);
                    pix_next    = '0;
                    last_next   = 1'b0;
                    rd_en       = 1'b1;
                    idx_next    = '0;
                    state_next  = ST_PIX;
                end
            end
            ST_PIX:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    kind_next   = 1'b1;
                    op_next     = csre_pkg::OP_END;
                    len_next    = 16'd0;
                    pix_next    = 32'(rd_data_reg);
                    last_next   = pix_done && !row_end_reg;
                    idx_next    = idx_inc;
                    if (pix_done)
                    begin
                        cnt_next   = '0;
                        skip_next  = transp_reg ? 16'd1 : 16'd0;
                        state_next = row_end_reg ? ST_EOL : ST_IDLE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_inc[AW-1:0];
                    end
                end
            end
            ST_EOL:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    kind_next   = 1'b0;
                    op_next     = tile_end_reg ? csre_pkg::OP_END : csre_pkg::OP_ENDL;
                    len_next    = 16'd0;
                    pix_next    = '0;
                    last_next   = 1'b1;
                    skip_next   = 16'd0;
                    cnt_next    = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            buf_mem[cnt_reg[AW-1:0]] <= q_item.pixel[PIXEL_BITS-1:0];
        if (rd_en)
            rd_data_reg <= buf_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            skip_reg   <= 16'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            skip_reg   <= skip_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        transp_reg   <= transp_next;
        row_end_reg  <= row_end_next;
        tile_end_reg <= tile_end_next;
        kind_reg     <= kind_next;
        op_reg       <= op_next;
        len_reg      <= len_next;
        pix_reg      <= pix_next;
        last_reg     <= last_next;
    end

    assign result_valid = ovalid_reg;
    assign kind         = kind_reg;
    assign op_code      = op_reg;
    assign run_length   = len_reg;
    assign pixel_out    = pix_reg;
    assign last         = last_reg;

    a_last_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && last_reg && !kind_reg) |->
            (op_reg == csre_pkg::OP_END || op_reg == csre_pkg::OP_ENDL))
        else $error("last set on a SKIP or COPY word");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_WIDTH))
        else $error("run count beyond buffer");

    a_pix_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PIX) |-> (idx_reg < cnt_reg))
        else $error("pixel index past run length");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && adv) |=> (state_reg == ST_PIX && cnt_reg != '0))
        else $error("COPY without a buffered run");

endmodule

// ===== hw/rtl/colorkey_sprite_rle_encoder.sv =====
// Top level of the color-key sprite run-length encoder.
// Depends on csre_pkg, csre_front, csre_queue and csre_back.
//
// Usage:
//   Pixels of one tile enter on pixel/pixel_valid/pixel_stall in raster order.
//   Result words leave on result_valid/result_stall with kind, op_code,
//   run_length, pixel_out and last; last marks the final word a pixel caused.
//   Config is a plain write port (cfg_write, cfg_index, cfg_data); the user
//   writes it only while the block is idle. The block does not enforce this.
// Throughput and flow:
//   The front accepts one pixel per cycle into a two-entry queue while the
//   queue is not full. The back sequencer pops one pixel word in IDLE and
//   emits its words (SKIP, COPY, each buffered pixel, ENDL/END) from the other
//   states, popping no new pixel word until it is back in IDLE. A pixel that
//   closes a run passes the queue and IDLE before the SKIP, COPY or EOL state
//   registers its first word; opaque pixels inside a run emit nothing.
// Reset:
//   Column, row and counts clear, registers take width 32, height 1,
//   one byte per pixel and key 0. The run buffer needs no clearing.
// Stall:
//   A stalled result word holds; the back waits and the queue fills, then
//   pixel_stall rises.
module colorkey_sprite_rle_encoder #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [31:0] pixel,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [2:0]  op_code,
    output logic [15:0] run_length,
    output logic [31:0] pixel_out,
    output logic        last
);

    csre_pkg::cfg_t  cfg_reg, cfg_next;
    csre_pkg::item_t push_item;
    csre_pkg::item_t q_item;
    logic            q_full;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                csre_pkg::CFG_TILE_WIDTH:  cfg_next.tile_width  = cfg_data[5:0];
                csre_pkg::CFG_TILE_HEIGHT: cfg_next.tile_height = cfg_data[15:0];
                csre_pkg::CFG_PIXEL_BYTES: cfg_next.pixel_bytes = cfg_data[2:0];
                csre_pkg::CFG_COLOR_KEY:   cfg_next.color_key   = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width  <= 6'd32;
            cfg_reg.tile_height <= 16'd1;
            cfg_reg.pixel_bytes <= 3'd1;
            cfg_reg.color_key   <= 32'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    csre_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    csre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    csre_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .op_code      (op_code),
        .run_length   (run_length),
        .pixel_out    (pixel_out),
        .last         (last)
    );

endmodule
